[design/ptd_pkg.sv]
package ptd_pkg;

    localparam int TIME_W = 32;
    localparam int FUNC_W = 8;
    localparam int DATA_W = 16;
    localparam int RATE_W = 16;
    localparam int SLOT_W = 3;
    localparam int STAT_W = 3;

    // request codes
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_ADD  = 2'd1;
    localparam logic [1:0] REQ_DEL  = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOFUNC   = 3'd2;
    localparam logic [STAT_W-1:0] ST_ZERORATE = 3'd3;
    localparam logic [STAT_W-1:0] ST_BADSLOT  = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [FUNC_W-1:0] func_tag;
        logic [DATA_W-1:0] data_tag;
        logic [RATE_W-1:0] rate;
        logic [SLOT_W-1:0] slot_index;
        logic [TIME_W-1:0] now_time;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              dispatched;
        logic [FUNC_W-1:0] out_func_tag;
        logic [DATA_W-1:0] out_data_tag;
        logic [SLOT_W-1:0] out_slot;
    } t_res;

    // one table slot
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [DATA_W-1:0] data;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] last_run;
    } t_entry;

    // scan token and the winner found so far, handed cell to cell
    typedef struct packed {
        logic              tok;
        logic              found;
        logic [FUNC_W-1:0] func;
        logic [DATA_W-1:0] data;
        logic [SLOT_W-1:0] slot;
    } t_link;

    typedef struct packed {
        logic wr;
        logic shift;
    } t_cell_ctl;

endpackage

[design/ptd_cell.sv]
module ptd_cell #(
    parameter int IDX = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ptd_pkg::t_cell_ctl        i_ctl,
    input  ptd_pkg::t_entry           i_new,
    input  ptd_pkg::t_entry           i_upper,
    input  logic [ptd_pkg::TIME_W-1:0] i_now,
    input  ptd_pkg::t_link            i_link,
    output ptd_pkg::t_link            o_link,
    output ptd_pkg::t_entry           o_entry
);

    localparam logic [ptd_pkg::SLOT_W-1:0] MY_SLOT = ptd_pkg::SLOT_W'(IDX);

    ptd_pkg::t_entry r_entry;
    ptd_pkg::t_link  r_link;
    logic [ptd_pkg::TIME_W-1:0] w_elapsed;
    logic w_due;
    logic w_take;

    assign w_elapsed = i_now - r_entry.last_run;
    assign w_due     = (r_entry.func != '0) && (w_elapsed >= r_entry.period);
    assign w_take    = i_link.tok && !i_link.found && w_due;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else begin
            priority if (i_ctl.shift) begin
                r_entry <= i_upper;
            end else if (i_ctl.wr) begin
                r_entry <= i_new;
            end else if (w_take) begin
                r_entry.last_run <= i_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link.tok <= 1'b0;
        end else begin
            r_link.tok <= i_link.tok;
        end
        if (i_link.tok) begin
            if (w_take) begin
                r_link.found <= 1'b1;
                r_link.func  <= r_entry.func;
                r_link.data  <= r_entry.data;
                r_link.slot  <= MY_SLOT;
            end else begin
                r_link.found <= i_link.found;
                r_link.func  <= i_link.func;
                r_link.data  <= i_link.data;
                r_link.slot  <= i_link.slot;
            end
        end
    end

    assign o_link  = r_link;
    assign o_entry = r_entry;

endmodule

[design/ptd_div.sv]
module ptd_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ptd_pkg::TIME_W-1:0] i_dividend,
    input  logic [ptd_pkg::RATE_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [ptd_pkg::TIME_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(ptd_pkg::TIME_W + 1);

    logic [ptd_pkg::RATE_W-1:0] r_rem;
    logic [ptd_pkg::RATE_W-1:0] r_dvs;
    logic [ptd_pkg::TIME_W-1:0] r_quo;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_done;
    logic [ptd_pkg::RATE_W:0]   w_trial;
    logic [ptd_pkg::RATE_W:0]   w_diff;
    logic                       w_ge;

    // one quotient bit a cycle, restoring
    assign w_trial = {r_rem, r_quo[ptd_pkg::TIME_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(ptd_pkg::TIME_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? w_diff[ptd_pkg::RATE_W-1:0] : w_trial[ptd_pkg::RATE_W-1:0];
            r_quo <= {r_quo[ptd_pkg::TIME_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

[design/periodic_task_dispatcher_top.sv]
// Delete, unused-code and rejected-add beats strobe a result in the cycle after acceptance;
//   an accepted add waits for the 32-step divider, a tick for the scan token.
// Throughput: short beats may follow every cycle; busy is held for the whole add or tick,
//   set by the divider for adds and by the token walking the chain of slot cells for ticks.
// Reset (i_rst_n low, synchronous): table and count cleared, tick_rate back to 1000.
// The receiver cannot stall: each result appears on o_res for one cycle with o_strobe.
module periodic_task_dispatcher_top #(
    parameter int MAX_TASKS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  ptd_pkg::t_req              i_req,
    output logic                       o_strobe,
    output ptd_pkg::t_res              o_res,
    input  logic                       i_cfg_we,
    input  logic [ptd_pkg::TIME_W-1:0] i_cfg_wdata
);

    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int CMP_W = (CNT_W > ptd_pkg::SLOT_W) ? CNT_W : ptd_pkg::SLOT_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_TASKS);

    ptd_pkg::t_state r_state, n_state;

    logic [ptd_pkg::TIME_W-1:0] r_tick_rate;
    logic [CNT_W-1:0]           r_count;
    logic [ptd_pkg::TIME_W-1:0] r_now;
    logic [ptd_pkg::FUNC_W-1:0] r_func;
    logic [ptd_pkg::DATA_W-1:0] r_data;
    logic                       r_kick;
    logic                       r_strobe;
    ptd_pkg::t_res              r_res;

    logic                       w_accept;
    logic                       w_is_tick;
    logic                       w_is_add;
    logic                       w_is_del;
    logic [ptd_pkg::STAT_W-1:0] w_add_status;
    logic                       w_del_ok;
    logic                       w_div_start;
    logic                       w_div_done;
    logic [ptd_pkg::TIME_W-1:0] w_quot;
    logic                       w_scan_end;
    ptd_pkg::t_entry            w_new;

    ptd_pkg::t_entry    w_entry [MAX_TASKS];
    ptd_pkg::t_entry    w_upper [MAX_TASKS];
    ptd_pkg::t_link     w_link  [MAX_TASKS+1];
    ptd_pkg::t_cell_ctl w_ctl   [MAX_TASKS];

    assign w_accept  = start && !busy;
    assign w_is_tick = (i_req.req_type == ptd_pkg::REQ_TICK);
    assign w_is_add  = (i_req.req_type == ptd_pkg::REQ_ADD);
    assign w_is_del  = (i_req.req_type == ptd_pkg::REQ_DEL);

    // add checks in order: full, no function, zero rate
    always_comb begin
        priority if (r_count == FULL_CNT) begin
            w_add_status = ptd_pkg::ST_FULL;
        end else if (i_req.func_tag == '0) begin
            w_add_status = ptd_pkg::ST_NOFUNC;
        end else if (i_req.rate == '0) begin
            w_add_status = ptd_pkg::ST_ZERORATE;
        end else begin
            w_add_status = ptd_pkg::ST_OK;
        end
    end

    assign w_del_ok    = (CMP_W'(i_req.slot_index) < CMP_W'(r_count));
    assign w_div_start = w_accept && w_is_add && (w_add_status == ptd_pkg::ST_OK);
    assign w_scan_end  = w_link[MAX_TASKS].tok;

    // period divider: tick_rate / rate
    ptd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_tick_rate),
        .i_divisor  (i_req.rate),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // entry written at the end of an add; fresh tasks start with last-run 0
    assign w_new = '{func: r_func, data: r_data, period: w_quot, last_run: '0};

    // token enters cell 0 with nothing found yet
    assign w_link[0] = '{tok: r_kick, found: 1'b0, func: '0, data: '0, slot: '0};

    // chain of slot cells: shift down on delete, token walks upward on tick
    for (genvar gi = 0; gi < MAX_TASKS; gi++) begin : g_cell
        localparam logic [CMP_W-1:0] IDX_C = CMP_W'(gi);

        if (gi == MAX_TASKS - 1) begin : g_top
            assign w_upper[gi] = '0;
        end else begin : g_mid
            assign w_upper[gi] = w_entry[gi+1];
        end

        assign w_ctl[gi].shift = w_accept && w_is_del && w_del_ok
                                 && (IDX_C >= CMP_W'(i_req.slot_index));
        assign w_ctl[gi].wr    = w_div_done && (IDX_C == CMP_W'(r_count));

        ptd_cell #(
            .IDX (gi)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[gi]),
            .i_new   (w_new),
            .i_upper (w_upper[gi]),
            .i_now   (r_now),
            .i_link  (w_link[gi]),
            .o_link  (w_link[gi+1]),
            .o_entry (w_entry[gi])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ptd_pkg::S_IDLE: begin
                if (w_accept && w_is_tick) begin
                    n_state = ptd_pkg::S_SCAN;
                end else if (w_div_start) begin
                    n_state = ptd_pkg::S_DIV;
                end
            end
            ptd_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_state = ptd_pkg::S_IDLE;
                end
            end
            ptd_pkg::S_SCAN: begin
                if (w_scan_end) begin
                    n_state = ptd_pkg::S_IDLE;
                end
            end
            default: n_state = ptd_pkg::S_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        unique case (r_state)
            ptd_pkg::S_IDLE: busy = 1'b0;
            default:         busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ptd_pkg::S_IDLE;
            r_tick_rate <= ptd_pkg::TIME_W'(1000);
            r_count     <= '0;
            r_kick      <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_kick   <= w_accept && w_is_tick;
            r_strobe <= 1'b0;
            if (i_cfg_we) begin
                r_tick_rate <= i_cfg_wdata;
            end
            if (w_accept) begin
                priority if (w_is_add) begin
                    // accepted adds report once the divider finishes
                    if (w_add_status != ptd_pkg::ST_OK) begin
                        r_strobe <= 1'b1;
                    end
                end else if (w_is_del) begin
                    r_strobe <= 1'b1;
                    if (w_del_ok) begin
                        r_count <= r_count - 1'b1;
                    end
                end else if (!w_is_tick) begin
                    r_strobe <= 1'b1;
                end
            end
            if (w_div_done) begin
                r_count  <= r_count + 1'b1;
                r_strobe <= 1'b1;
            end
            if (w_scan_end) begin
                r_strobe <= 1'b1;
            end
        end
    end

    // result and request payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_now  <= i_req.now_time;
            r_func <= i_req.func_tag;
            r_data <= i_req.data_tag;
            r_res  <= '0;
            if (w_is_add) begin
                r_res.status <= w_add_status;
            end else if (w_is_del && !w_del_ok) begin
                r_res.status <= ptd_pkg::ST_BADSLOT;
            end
        end
        if (w_div_done) begin
            r_res <= '0;
        end
        if (w_scan_end) begin
            r_res.status       <= ptd_pkg::ST_OK;
            r_res.dispatched   <= w_link[MAX_TASKS].found;
            r_res.out_func_tag <= w_link[MAX_TASKS].func;
            r_res.out_data_tag <= w_link[MAX_TASKS].data;
            r_res.out_slot     <= w_link[MAX_TASKS].slot;
        end
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    // count never passes the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("task count beyond table depth");

    // divider only finishes while an add is in flight
    a_div_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ptd_pkg::S_DIV))
        else $error("divider finished outside an add");

    // token leaves the chain only during a scan
    a_scan_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scan_end |-> (r_state == ptd_pkg::S_SCAN))
        else $error("scan token out of step");

    // a dispatch always reports ok
    a_disp_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.dispatched) |-> (o_res.status == ptd_pkg::ST_OK))
        else $error("dispatch with non-ok status");

    // a finished add or tick frees the block in the next cycle
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_div_done || w_scan_end) |=> !busy)
        else $error("block still busy after result");

endmodule

[test/periodic_task_dispatcher_top_tb.sv]
`timescale 1ns / 100ps

module periodic_task_dispatcher_top_tb;

    localparam int MAX_TASKS       = 8;
    localparam int N_PHASES        = 6;
    localparam int ITEMS_PER_PHASE = 250;
    // longest beat is an accepted add, which waits on the divider; leave plenty on top
    localparam int SETTLE_CYCLES   = MAX_TASKS + 40;
    // request code the block must ignore
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // one row of the directed table: the beat, and the status to pin if pinned
    typedef struct {
        ptd_pkg::t_req              req;
        bit                         pinned;
        logic [ptd_pkg::STAT_W-1:0] status;
    } t_row;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       start       = 1'b0;
    logic                       busy;
    ptd_pkg::t_req              i_req       = '0;
    logic                       o_strobe;
    ptd_pkg::t_res              o_res;
    logic                       i_cfg_we    = 1'b0;
    logic [ptd_pkg::TIME_W-1:0] i_cfg_wdata = '0;

    // shadow of the task table, the count and the tick rate
    ptd_pkg::t_entry            sched_tbl [MAX_TASKS];
    int unsigned                sched_count;
    logic [ptd_pkg::TIME_W-1:0] tick_rate_q;

    ptd_pkg::t_res outcome_q [$];   // results still owed by the block, oldest first
    t_row          dir_tab [$];
    int            idle_pct;        // chance, in percent, of holding start low per cycle
    int            n_mismatch;

    periodic_task_dispatcher_top #(
        .MAX_TASKS (MAX_TASKS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_strobe    (o_strobe),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Advance the shadow table by one request and return the result it owes.
    function automatic ptd_pkg::t_res apply_request(ptd_pkg::t_req r);
        ptd_pkg::t_res              res;
        logic [ptd_pkg::TIME_W-1:0] elapsed;
        bit                         hit;
        res = '0;
        hit = 1'b0;
        case (r.req_type)
            ptd_pkg::REQ_TICK: begin
                // first due slot in table order wins; elapsed time wraps at 2^32
                for (int i = 0; i < MAX_TASKS; i++) begin
                    elapsed = r.now_time - sched_tbl[i].last_run;
                    if (!hit && i < sched_count && sched_tbl[i].func != '0 &&
                            elapsed >= sched_tbl[i].period) begin
                        hit              = 1'b1;
                        res.dispatched   = 1'b1;
                        res.out_func_tag = sched_tbl[i].func;
                        res.out_data_tag = sched_tbl[i].data;
                        res.out_slot     = ptd_pkg::SLOT_W'(i);
                        sched_tbl[i].last_run = r.now_time;
                    end
                end
            end
            ptd_pkg::REQ_ADD: begin
                // full wins over a missing function, which wins over a zero rate
                if (sched_count >= MAX_TASKS) begin
                    res.status = ptd_pkg::ST_FULL;
                end else if (r.func_tag == '0) begin
                    res.status = ptd_pkg::ST_NOFUNC;
                end else if (r.rate == '0) begin
                    res.status = ptd_pkg::ST_ZERORATE;
                end else begin
                    sched_tbl[sched_count] = '{func: r.func_tag, data: r.data_tag,
                        period: tick_rate_q / ptd_pkg::TIME_W'(r.rate),
                        last_run: '0};
                    sched_count++;
                end
            end
            ptd_pkg::REQ_DEL: begin
                if (r.slot_index >= sched_count) begin
                    res.status = ptd_pkg::ST_BADSLOT;
                end else begin
                    // close the gap and clear the top slot
                    for (int i = 0; i < MAX_TASKS - 1; i++)
                        if (i >= r.slot_index) sched_tbl[i] = sched_tbl[i + 1];
                    sched_tbl[MAX_TASKS - 1] = '0;
                    sched_count--;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic void add_row(logic [1:0] req, int func, int data, int rate, int slot,
                                    logic [ptd_pkg::TIME_W-1:0] now, bit pinned,
                                    logic [ptd_pkg::STAT_W-1:0] status);
        t_row row;
        row.req            = '0;
        row.req.req_type   = req;
        row.req.func_tag   = ptd_pkg::FUNC_W'(func);
        row.req.data_tag   = ptd_pkg::DATA_W'(data);
        row.req.rate       = ptd_pkg::RATE_W'(rate);
        row.req.slot_index = ptd_pkg::SLOT_W'(slot);
        row.req.now_time   = now;
        row.pinned         = pinned;
        row.status         = status;
        dir_tab.push_back(row);
    endfunction

    // Offer one beat, hold it until accepted, then log what it owes.
    // Call at a rising edge; start is left high so back-to-back beats need no gap.
    task automatic send_beat(input ptd_pkg::t_req r, input bit pinned,
                             input logic [ptd_pkg::STAT_W-1:0] status);
        ptd_pkg::t_res res;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy !== 1'b0);
        res = apply_request(r);
        if (pinned) begin
            // pinned rows carry no dispatch, only a status
            res        = '0;
            res.status = status;
        end
        outcome_q.push_back(res);
    endtask

    // Drop start and wait until every owed result is in, then let the block settle.
    task automatic wait_all_results();
        start <= 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Check each strobed result against the oldest outstanding one.
    always @(posedge i_clk) begin
        ptd_pkg::t_res want;
        if (i_rst_n && o_strobe) begin
            if (outcome_q.size() == 0) begin
                if (n_mismatch < 10)
                    $display("unexpected result beat: %p", o_res);
                n_mismatch++;
            end else begin
                want = outcome_q.pop_front();
                if (o_res.status !== want.status || o_res.dispatched !== want.dispatched ||
                        o_res.out_func_tag !== want.out_func_tag ||
                        o_res.out_data_tag !== want.out_data_tag ||
                        o_res.out_slot !== want.out_slot) begin
                    if (n_mismatch < 10)
                        $display("result mismatch: expected %p, got %p", want, o_res);
                    n_mismatch++;
                end
            end
        end
    end

    initial begin
        ptd_pkg::t_req              r;
        int                         n_items;
        int                         pick;
        logic [95:0]                noise;
        logic [ptd_pkg::TIME_W-1:0] now_clk;
        logic [ptd_pkg::TIME_W-1:0] rate_plan [N_PHASES];
        int                         idle_plan [N_PHASES];

        tick_rate_q = 32'd1000;
        sched_count = 0;
        foreach (sched_tbl[k]) sched_tbl[k] = '0;
        n_mismatch = 0;
        idle_pct   = 29;
        now_clk    = '0;
        // extremes of the tick rate, zero among them, plus a couple of ordinary ones
        rate_plan = '{32'hFFFF_FFFF, 32'd1, 32'd0, 32'($urandom_range(1, 1 << 20)),
                      32'd1000, 32'($urandom)};
        idle_plan = '{0, 85, 0, 29, 85, 0};

        // Directed table, run at the reset tick rate of 1000.
        // Empty table: tick does nothing, delete is out of range.
        add_row(ptd_pkg::REQ_TICK, 0, 0, 0, 0, 32'd0, 1, ptd_pkg::ST_OK);
        add_row(ptd_pkg::REQ_DEL,  0, 0, 0, 0, 32'd0, 1, ptd_pkg::ST_BADSLOT);
        // rejected adds, checked in priority order
        add_row(ptd_pkg::REQ_ADD,  0, 0, 5, 0, 32'd0, 1, ptd_pkg::ST_NOFUNC);
        add_row(ptd_pkg::REQ_ADD,  1, 0, 0, 0, 32'd0, 1, ptd_pkg::ST_ZERORATE);
        add_row(ptd_pkg::REQ_ADD,  0, 0, 0, 0, 32'd0, 1, ptd_pkg::ST_NOFUNC);
        // unused request code with every field at its top: ignored
        add_row(REQ_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF, 7, 32'hFFFF_FFFF, 1, ptd_pkg::ST_OK);
        // rate above tick rate gives period 0; rate 1 gives period 1000
        add_row(ptd_pkg::REQ_ADD, 8'hFF, 16'hFFFF, 16'hFFFF, 0, 32'd0, 1, ptd_pkg::ST_OK);
        add_row(ptd_pkg::REQ_ADD,  1, 0, 1, 0, 32'd0, 1, ptd_pkg::ST_OK);
        add_row(ptd_pkg::REQ_TICK, 0, 0, 0, 0, 32'd0, 0, ptd_pkg::ST_OK);
        // drop the always-due slot so the slow one moves to slot 0
        add_row(ptd_pkg::REQ_DEL,  0, 0, 0, 0, 32'd0, 1, ptd_pkg::ST_OK);
        add_row(ptd_pkg::REQ_TICK, 0, 0, 0, 0, 32'd999, 0, ptd_pkg::ST_OK);
        add_row(ptd_pkg::REQ_TICK, 0, 0, 0, 0, 32'd1000, 0, ptd_pkg::ST_OK);
        add_row(ptd_pkg::REQ_TICK, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, ptd_pkg::ST_OK);
        // elapsed time wraps past zero
        add_row(ptd_pkg::REQ_TICK, 0, 0, 0, 0, 32'd998, 0, ptd_pkg::ST_OK);
        add_row(ptd_pkg::REQ_TICK, 0, 0, 0, 0, 32'd999, 0, ptd_pkg::ST_OK);
        // fill the table, then hit it while full
        for (int k = 0; k < MAX_TASKS - 1; k++)
            add_row(ptd_pkg::REQ_ADD, k + 2, 16'h5A00 + k, 1 << (2 * k), 0, 32'd0, 1,
                    ptd_pkg::ST_OK);
        add_row(ptd_pkg::REQ_ADD,  9, 0, 3, 0, 32'd0, 1, ptd_pkg::ST_FULL);
        add_row(ptd_pkg::REQ_ADD,  0, 0, 0, 0, 32'd0, 1, ptd_pkg::ST_FULL);
        // delete the top slot, then the same index is out of range
        add_row(ptd_pkg::REQ_DEL,  0, 0, 0, 7, 32'd0, 1, ptd_pkg::ST_OK);
        add_row(ptd_pkg::REQ_DEL,  0, 0, 0, 7, 32'd0, 1, ptd_pkg::ST_BADSLOT);
        add_row(ptd_pkg::REQ_TICK, 0, 0, 0, 0, 32'd5000, 0, ptd_pkg::ST_OK);

        // hold reset low from the start, then release it once for good
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[k]) send_beat(dir_tab[k].req, dir_tab[k].pinned, dir_tab[k].status);

        // Random phases: write the tick rate while idle, then drive mostly
        // sensible traffic with random content and a little noise.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_all_results();
            i_cfg_we    <= 1'b1;
            i_cfg_wdata <= rate_plan[ph];
            @(posedge i_clk);
            i_cfg_we    <= 1'b0;
            tick_rate_q = rate_plan[ph];
            idle_pct    = idle_plan[ph];
            n_items     = 0;
            while (n_items < ITEMS_PER_PHASE) begin
                // start from noise in every field, then shape the fields that matter
                noise = {$urandom, $urandom, $urandom};
                r     = ptd_pkg::t_req'(noise[$bits(ptd_pkg::t_req)-1:0]);
                pick  = $urandom_range(99);
                if (pick < 45) begin
                    r.req_type = ptd_pkg::REQ_TICK;
                    pick = $urandom_range(9);
                    if (pick == 0) begin
                        now_clk = $urandom;
                    end else if (pick == 1) begin
                        now_clk = 32'hFFFF_FFFF - $urandom_range(0, 40);
                    end else begin
                        // advance time on the scale of the periods in use
                        now_clk += (tick_rate_q >> $urandom_range(0, 10)) +
                                   $urandom_range(0, 20);
                    end
                    r.now_time = now_clk;
                end else if (pick < 75) begin
                    r.req_type = ptd_pkg::REQ_ADD;
                    r.func_tag = ($urandom_range(99) < 8) ? '0 :
                                 ptd_pkg::FUNC_W'($urandom_range(1, 255));
                    pick = $urandom_range(99);
                    if (pick < 70)
                        r.rate = ptd_pkg::RATE_W'($urandom_range(1, 32));
                    else if (pick < 85)
                        r.rate = ptd_pkg::RATE_W'($urandom_range(1, 65535));
                    else if (pick < 95)
                        r.rate = '0;
                    else
                        r.rate = '1;
                end else if (pick < 93) begin
                    r.req_type = ptd_pkg::REQ_DEL;
                    if (sched_count > 0 && $urandom_range(9) < 8)
                        r.slot_index = ptd_pkg::SLOT_W'($urandom_range(0, sched_count - 1));
                end else begin
                    r.req_type = REQ_UNUSED;
                end
                send_beat(r, 1'b0, ptd_pkg::ST_OK);
                if (r.req_type != REQ_UNUSED) n_items++;
            end
        end

        wait_all_results();
        if (n_mismatch == 0 && outcome_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog: far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
